>>> rtl/euler_angles_to_basis_vectors_defines.svh
// Assertion macros for the RTL.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH

// Checks that an implication holds on every clock edge outside reset.
`define EABV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define EABV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/eabv_pkg.sv
`default_nettype none
package eabv_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int AngleFracDefault = 7;
  localparam int MaxStages = 24;
  localparam int AccFrac = 24;
  localparam int DataW = 34;
  localparam int AngW = 36;
  localparam int ProdW = 34;
  localparam logic signed [DataW-1:0] GainQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } vectors_t;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [AngW-1:0] z;
    logic flip;
  } rot_t;

  function automatic logic signed [AngW-1:0] atan_deg(input int idx);
    logic signed [AngW-1:0] r;
    begin
      unique case (idx)
        0: r = 36'sd754974720;
        1: r = 36'sd445687602;
        2: r = 36'sd235489088;
        3: r = 36'sd119537938;
        4: r = 36'sd60000934;
        5: r = 36'sd30029717;
        6: r = 36'sd15018523;
        7: r = 36'sd7509719;
        8: r = 36'sd3754917;
        9: r = 36'sd1877466;
        10: r = 36'sd938734;
        11: r = 36'sd469367;
        12: r = 36'sd234684;
        13: r = 36'sd117342;
        14: r = 36'sd58671;
        15: r = 36'sd29335;
        16: r = 36'sd14668;
        17: r = 36'sd7334;
        18: r = 36'sd3667;
        19: r = 36'sd1833;
        20: r = 36'sd917;
        21: r = 36'sd458;
        22: r = 36'sd229;
        23: r = 36'sd115;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Product of two Q4.30 values, rounded back to Q4.30.
  function automatic logic signed [ProdW-1:0] mulq(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    logic signed [2*DataW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< 29);
      return ProdW'(p >>> 30);
    end
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [ProdW+1:0] v);
    logic signed [ProdW+1:0] r;
    begin
      r = (v + 36'sd16384) >>> 15;
      if (r > 36'sd32767) begin
        return 16'sh7fff;
      end else if (r < -36'sd32768) begin
        return 16'sh8000;
      end
      return r[15:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/euler_angles_to_basis_vectors.sv
// Takes one angle triple per cycle (busy is never raised) and gives the forward, right and
// up vectors on result with done high for one cycle (at most 24 CORDIC stages are used).
// The latency is set by one range-reduction stage, one CORDIC cell per stage in a row, and
// three product stages. The receiver cannot stall, so each result must be taken on its beat.
`default_nettype none
`include "euler_angles_to_basis_vectors_defines.svh"
module euler_angles_to_basis_vectors #(
  parameter int CordicStages = eabv_pkg::CordicStagesDefault,
  parameter int AngleFrac = eabv_pkg::AngleFracDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  eabv_pkg::angles_t angles,
  output logic done,
  output eabv_pkg::vectors_t result
);

  localparam int Used = (CordicStages > eabv_pkg::MaxStages) ? eabv_pkg::MaxStages
                                                             : CordicStages;
  localparam int Lat = Used + 4;

  eabv_pkg::rot_t chain [3][Used+1];
  logic signed [eabv_pkg::DataW-1:0] s [3];
  logic signed [eabv_pkg::DataW-1:0] c [3];
  logic [Lat-1:0] valid;
  logic accept;

  assign busy = 1'b0;
  assign accept = start && !busy;

  eabv_reduce #(.AngleFrac(AngleFrac)) u_red_p (.clk(clk), .angle(angles.pitch_angle),
                                                .rot(chain[0][0]));
  eabv_reduce #(.AngleFrac(AngleFrac)) u_red_y (.clk(clk), .angle(angles.yaw_angle),
                                                .rot(chain[1][0]));
  eabv_reduce #(.AngleFrac(AngleFrac)) u_red_r (.clk(clk), .angle(angles.roll_angle),
                                                .rot(chain[2][0]));

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar i = 0; i < Used; i++) begin : g_cell
      eabv_cell #(.Index(i)) u_cell (.clk(clk), .rot_in(chain[a][i]),
                                     .rot_out(chain[a][i+1]));
    end
    assign s[a] = chain[a][Used].y;
    assign c[a] = chain[a][Used].flip ? -chain[a][Used].x : chain[a][Used].x;
  end

  eabv_combine u_comb (.clk(clk), .sp(s[0]), .cp(c[0]), .sy(s[1]), .cy(c[1]),
                       .sr(s[2]), .cr(c[2]), .vec(result));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Lat-2:0], accept};
    end
  end

  assign done = valid[Lat-1];

  `EABV_ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy, "busy raised")
  `EABV_ASSERT_NEXT(a_valid_shift, clk, rst, accept, valid[0], "accepted beat lost")
  `EABV_ASSERT_NEXT(a_done_follows, clk, rst, valid[Lat-2], done, "result beat lost")
  `EABV_ASSERT_NEXT(a_no_spurious, clk, rst, !valid[Lat-2], !done, "spurious result beat")

endmodule
`default_nettype wire

>>> rtl/eabv_reduce.sv
`default_nettype none
module eabv_reduce #(
  parameter int AngleFrac = eabv_pkg::AngleFracDefault
) (
  input  wire logic clk,
  input  wire logic signed [15:0] angle,
  output eabv_pkg::rot_t rot
);

  localparam int RW = 18 + AngleFrac;
  localparam logic signed [RW-1:0] Full = RW'(360) <<< AngleFrac;
  localparam logic signed [RW-1:0] Half = RW'(180) <<< AngleFrac;
  localparam logic signed [RW-1:0] Quarter = RW'(90) <<< AngleFrac;
  localparam int Turns = (32768 >>> AngleFrac) / 360 + 1;

  logic signed [RW-1:0] a;
  logic signed [RW-1:0] r;
  logic flip;
  eabv_pkg::rot_t rot_next;

  // One conditional step per whole turn that a 16-bit input can span folds it into one turn.
  always_comb begin
    a = RW'(angle);
    r = a;
    for (int k = 0; k < Turns; k++) begin
      if (r >= Full) r = r - Full;
      if (r < 0) r = r + Full;
    end
    if (r > Half) r = r - Full;
    flip = 1'b0;
    if (r > Quarter) begin
      r = Half - r;
      flip = 1'b1;
    end else if (r < -Quarter) begin
      r = -Half - r;
      flip = 1'b1;
    end
    rot_next.x = eabv_pkg::GainQ30;
    rot_next.y = '0;
    rot_next.z = eabv_pkg::AngW'(r) <<< (eabv_pkg::AccFrac - AngleFrac);
    rot_next.flip = flip;
  end

  always_ff @(posedge clk) begin
    rot <= rot_next;
  end

endmodule
`default_nettype wire

>>> rtl/eabv_cell.sv
`default_nettype none
module eabv_cell #(
  parameter int Index = 0
) (
  input  wire logic clk,
  input  eabv_pkg::rot_t rot_in,
  output eabv_pkg::rot_t rot_out
);

  localparam logic signed [eabv_pkg::AngW-1:0] Atan = eabv_pkg::atan_deg(Index);

  eabv_pkg::rot_t rot_next;
  logic signed [eabv_pkg::DataW-1:0] dx;
  logic signed [eabv_pkg::DataW-1:0] dy;

  always_comb begin
    dx = rot_in.y >>> Index;
    dy = rot_in.x >>> Index;
    rot_next.flip = rot_in.flip;
    if (!rot_in.z[eabv_pkg::AngW-1]) begin
      rot_next.x = rot_in.x - dx;
      rot_next.y = rot_in.y + dy;
      rot_next.z = rot_in.z - Atan;
    end else begin
      rot_next.x = rot_in.x + dx;
      rot_next.y = rot_in.y - dy;
      rot_next.z = rot_in.z + Atan;
    end
  end

  always_ff @(posedge clk) begin
    rot_out <= rot_next;
  end

endmodule
`default_nettype wire

>>> rtl/eabv_combine.sv
`default_nettype none
module eabv_combine (
  input  wire logic clk,
  input  wire logic signed [eabv_pkg::DataW-1:0] sp,
  input  wire logic signed [eabv_pkg::DataW-1:0] cp,
  input  wire logic signed [eabv_pkg::DataW-1:0] sy,
  input  wire logic signed [eabv_pkg::DataW-1:0] cy,
  input  wire logic signed [eabv_pkg::DataW-1:0] sr,
  input  wire logic signed [eabv_pkg::DataW-1:0] cr,
  output eabv_pkg::vectors_t vec
);

  localparam int W = eabv_pkg::ProdW;

  logic signed [W-1:0] spcy, spsy, cpcy, cpsy, crsy, crcy, srsy, srcy, srcp, crcp, nsp;
  logic signed [W-1:0] s1_sr, s1_cr;
  logic signed [W-1:0] a_x, a_y, b_x, b_y;
  logic signed [W-1:0] t_srx, t_sry, t_crx, t_cry;
  logic signed [15:0] fx, fy, fz, rz, uz;
  logic signed [15:0] s2_fx, s2_fy, s2_fz, s2_rz, s2_uz;

  always_ff @(posedge clk) begin
    spcy <= eabv_pkg::mulq(sp, cy);
    spsy <= eabv_pkg::mulq(sp, sy);
    cpcy <= eabv_pkg::mulq(cp, cy);
    cpsy <= eabv_pkg::mulq(cp, sy);
    crsy <= eabv_pkg::mulq(cr, sy);
    crcy <= eabv_pkg::mulq(cr, cy);
    srsy <= eabv_pkg::mulq(sr, sy);
    srcy <= eabv_pkg::mulq(sr, cy);
    srcp <= eabv_pkg::mulq(sr, cp);
    crcp <= eabv_pkg::mulq(cr, cp);
    nsp <= -W'(sp);
    s1_sr <= W'(sr);
    s1_cr <= W'(cr);
  end

  assign fx = eabv_pkg::to_q15((W+2)'(cpcy));
  assign fy = eabv_pkg::to_q15((W+2)'(cpsy));
  assign fz = eabv_pkg::to_q15((W+2)'(nsp));
  assign rz = eabv_pkg::to_q15(-(W+2)'(srcp));
  assign uz = eabv_pkg::to_q15((W+2)'(crcp));

  always_ff @(posedge clk) begin
    t_srx <= eabv_pkg::mulq(eabv_pkg::DataW'(s1_sr), eabv_pkg::DataW'(spcy));
    t_sry <= eabv_pkg::mulq(eabv_pkg::DataW'(s1_sr), eabv_pkg::DataW'(spsy));
    t_crx <= eabv_pkg::mulq(eabv_pkg::DataW'(s1_cr), eabv_pkg::DataW'(spcy));
    t_cry <= eabv_pkg::mulq(eabv_pkg::DataW'(s1_cr), eabv_pkg::DataW'(spsy));
    a_x <= crsy;
    a_y <= crcy;
    b_x <= srsy;
    b_y <= srcy;
    s2_fx <= fx;
    s2_fy <= fy;
    s2_fz <= fz;
    s2_rz <= rz;
    s2_uz <= uz;
  end

  always_ff @(posedge clk) begin
    vec.forward_x <= s2_fx;
    vec.forward_y <= s2_fy;
    vec.forward_z <= s2_fz;
    vec.right_x <= eabv_pkg::to_q15(-(W+2)'(t_srx) + (W+2)'(a_x));
    vec.right_y <= eabv_pkg::to_q15(-(W+2)'(t_sry) - (W+2)'(a_y));
    vec.right_z <= s2_rz;
    vec.up_x <= eabv_pkg::to_q15((W+2)'(t_crx) + (W+2)'(b_x));
    vec.up_y <= eabv_pkg::to_q15((W+2)'(t_cry) - (W+2)'(b_y));
    vec.up_z <= s2_uz;
  end

endmodule
`default_nettype wire

>>> dv/euler_angles_to_basis_vectors_tb.sv
`timescale 1ns / 1ps
module euler_angles_to_basis_vectors_tb;

  localparam int Stages = eabv_pkg::CordicStagesDefault;
  localparam int FracBits = eabv_pkg::AngleFracDefault;
  localparam int Latency = Stages + 4;
  localparam int RandomBeats = 450;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  eabv_pkg::angles_t angles;
  logic done;
  eabv_pkg::vectors_t result;

  eabv_pkg::vectors_t pending_vectors[$];
  int mismatch_count;
  int beats_sent;
  int vectors_seen;
  int sender_idle_pct;

  euler_angles_to_basis_vectors DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .angles(angles),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // Arithmetic right shift, which floors a signed value.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return shr_floor(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic signed [15:0] sat_q15(longint v);
    longint r;
    r = shr_floor(v + (64'sd1 <<< 14), 15);
    if (r > 32767) begin
      return 16'sh7fff;
    end else if (r < -32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic longint atan_step(int i);
    longint tab[24];
    tab = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509719, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334,
            3667, 1833, 917, 458, 229, 115};
    return tab[i];
  endfunction

  task automatic sine_cosine(input logic signed [15:0] ang, output longint s,
                             output longint c);
    longint full;
    longint half;
    longint quarter;
    longint r;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit flip;
    full = 360 <<< FracBits;
    half = 180 <<< FracBits;
    quarter = 90 <<< FracBits;
    r = longint'(ang) % full;
    flip = 1'b0;
    if (r < 0) r += full;
    if (r > half) r -= full;
    if (r > quarter) begin
      r = half - r;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r = -half - r;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = r <<< (eabv_pkg::AccFrac - FracBits);
    for (int i = 0; i < Stages && i < eabv_pkg::MaxStages; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  task automatic predict_basis(input eabv_pkg::angles_t a, output eabv_pkg::vectors_t v);
    longint sp, cp, sy, cy, sr, cr, spcy, spsy;
    sine_cosine(a.pitch_angle, sp, cp);
    sine_cosine(a.yaw_angle, sy, cy);
    sine_cosine(a.roll_angle, sr, cr);
    spcy = qmul(sp, cy);
    spsy = qmul(sp, sy);
    v.forward_x = sat_q15(qmul(cp, cy));
    v.forward_y = sat_q15(qmul(cp, sy));
    v.forward_z = sat_q15(-sp);
    v.right_x = sat_q15(-qmul(sr, spcy) + qmul(cr, sy));
    v.right_y = sat_q15(-qmul(sr, spsy) - qmul(cr, cy));
    v.right_z = sat_q15(-qmul(sr, cp));
    v.up_x = sat_q15(qmul(cr, spcy) + qmul(sr, sy));
    v.up_y = sat_q15(qmul(cr, spsy) - qmul(sr, cy));
    v.up_z = sat_q15(qmul(cr, cp));
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, want);
  endtask

  always @(posedge clk) begin
    eabv_pkg::vectors_t want;
    if (!rst && done) begin
      vectors_seen++;
      if (pending_vectors.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = pending_vectors.pop_front();
        if (result.forward_x !== want.forward_x)
          report_mismatch("forward_x", result.forward_x, want.forward_x);
        if (result.forward_y !== want.forward_y)
          report_mismatch("forward_y", result.forward_y, want.forward_y);
        if (result.forward_z !== want.forward_z)
          report_mismatch("forward_z", result.forward_z, want.forward_z);
        if (result.right_x !== want.right_x)
          report_mismatch("right_x", result.right_x, want.right_x);
        if (result.right_y !== want.right_y)
          report_mismatch("right_y", result.right_y, want.right_y);
        if (result.right_z !== want.right_z)
          report_mismatch("right_z", result.right_z, want.right_z);
        if (result.up_x !== want.up_x) report_mismatch("up_x", result.up_x, want.up_x);
        if (result.up_y !== want.up_y) report_mismatch("up_y", result.up_y, want.up_y);
        if (result.up_z !== want.up_z) report_mismatch("up_z", result.up_z, want.up_z);
      end
    end
  end

  // Drives one beat; the expectation is queued at the accepting edge.
  task automatic send_angles(input eabv_pkg::angles_t a, input bit use_typed,
                             input eabv_pkg::vectors_t typed);
    eabv_pkg::vectors_t want;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    angles <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (use_typed) want = typed;
    else predict_basis(a, want);
    pending_vectors.push_back(want);
    beats_sent++;
  endtask

  typedef struct {
    eabv_pkg::angles_t a;
    bit typed;
    eabv_pkg::vectors_t v;
  } stim_row_t;

  function automatic eabv_pkg::angles_t mk(int p, int y, int r);
    eabv_pkg::angles_t a;
    a.pitch_angle = 16'(p);
    a.yaw_angle = 16'(y);
    a.roll_angle = 16'(r);
    return a;
  endfunction

  function automatic eabv_pkg::angles_t rand_angles();
    eabv_pkg::angles_t a;
    a = eabv_pkg::angles_t'(48'({$urandom, $urandom}));
    if ($urandom_range(3) == 0) begin
      a.pitch_angle = 16'($urandom_range(0, 8) * (45 <<< FracBits) - (180 <<< FracBits));
      a.roll_angle = 16'($urandom_range(0, 8) * (45 <<< FracBits) - (180 <<< FracBits));
    end
    return a;
  endfunction

  initial begin
    stim_row_t rows[$];
    int deg;
    int phase;
    eabv_pkg::vectors_t none;
    none = '0;
    deg = 1 <<< FracBits;
    mismatch_count = 0;
    beats_sent = 0;
    vectors_seen = 0;
    sender_idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    angles = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero angles give the identity frame, with the right vector along -y. The CORDIC
    // residual leaves a sine of about -1.76e-5, which rounds to one LSB on the sine terms.
    rows.push_back('{mk(0, 0, 0), 1'b1,
                     '{16'sh7fff, 16'shffff, 16'sh0001, 16'shffff, 16'sh8000, 16'sh0001,
                       16'shffff, 16'sh0001, 16'sh7fff}});
    rows.push_back('{mk(90 * deg, 0, 0), 1'b0, none});
    rows.push_back('{mk(-90 * deg, 0, 0), 1'b0, none});
    rows.push_back('{mk(0, 90 * deg, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, 90 * deg), 1'b0, none});
    rows.push_back('{mk(180 * deg, 180 * deg, 180 * deg), 1'b0, none});
    rows.push_back('{mk(-180 * deg, -180 * deg, -180 * deg), 1'b0, none});
    rows.push_back('{mk(360 * deg, -360 * deg, 270 * deg), 1'b0, none});
    rows.push_back('{mk(32767, 32767, 32767), 1'b0, none});
    rows.push_back('{mk(-32768, -32768, -32768), 1'b0, none});
    rows.push_back('{mk(-1, 1, -1), 1'b0, none});
    rows.push_back('{mk(45 * deg, 30 * deg, 60 * deg), 1'b0, none});
    rows.push_back('{mk(89 * deg + 127, 91 * deg, -91 * deg), 1'b0, none});
    rows.push_back('{mk(16'h5555, 16'haaaa, 16'h7f80), 1'b0, none});
    foreach (rows[i]) send_angles(rows[i].a, rows[i].typed, rows[i].v);

    for (int n = 0; n < RandomBeats; n++) begin
      phase = n / 75;
      sender_idle_pct = (phase == 1 || phase == 4) ? 45 : (phase == 3) ? 16 : 0;
      if (n == 225) begin
        start <= 1'b0;
        while (pending_vectors.size() != 0) @(posedge clk);
      end
      send_angles(rand_angles(), 1'b0, none);
    end
    start <= 1'b0;

    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    $display("Covered %0d angle triples (directed extremes, wraps, random) with %0d vector beats.",
             beats_sent, vectors_seen);
    $display("Sender ran with no gaps and with gaps of 16 and 45 percent.");
    if (mismatch_count == 0 && pending_vectors.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/eabv_pkg.sv
rtl/eabv_reduce.sv
rtl/eabv_cell.sv
rtl/eabv_combine.sv
rtl/euler_angles_to_basis_vectors.sv
dv/euler_angles_to_basis_vectors_tb.sv
